// ===== design/vak_pkg.sv =====
package vak_pkg;

    localparam int NUM_VOICES = 24;
    localparam int VOICE_W    = 5;
    localparam int MASK_W     = 24;
    localparam int TRACK_W    = 8;
    localparam int NOTE_W     = 7;
    localparam int ACT_W      = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;

    localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;

    // request travelling down the voice chain, picking up mask bits as it goes
    typedef struct packed {
        logic               valid;
        logic [ACT_W-1:0]   action;
        logic [TRACK_W-1:0] track;
        logic [NOTE_W-1:0]  note;
        logic               rev;
        logic               found;
        logic [VOICE_W-1:0] voice;
        logic [MASK_W-1:0]  on_mask;
        logic [MASK_W-1:0]  off_mask;
        logic [MASK_W-1:0]  rev_mask;
    } t_token;

endpackage

// ===== design/vak_cell.sv =====
module vak_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [vak_pkg::VOICE_W-1:0]  i_idx,
    input  logic [vak_pkg::MASK_W-1:0]   i_bit,
    input  vak_pkg::t_token              i_tok,
    output vak_pkg::t_token              o_tok
);
    import vak_pkg::*;

    logic               r_busy;
    logic [TRACK_W-1:0] r_track;
    logic [NOTE_W-1:0]  r_note;
    logic               r_on;
    logic               r_off;
    logic               r_rev;
    t_token             r_tok;

    logic               n_busy;
    logic               n_claim;
    logic               n_on;
    logic               n_off;
    logic               n_rev;
    t_token             n_tok;

    always_comb begin
        n_busy  = r_busy;
        n_claim = 1'b0;
        n_on    = r_on;
        n_off   = r_off;
        n_rev   = r_rev;
        n_tok   = i_tok;
        if (i_tok.valid && !i_tok.found) begin
            case (i_tok.action)
                ACT_NOTE_ON: begin
                    if (!r_busy) begin
                        n_busy      = 1'b1;
                        n_claim     = 1'b1;
                        n_on        = 1'b1;
                        n_rev       = i_tok.rev;
                        n_tok.found = 1'b1;
                        n_tok.voice = i_idx;
                    end
                end
                ACT_NOTE_OFF: begin
                    if (r_busy && r_track == i_tok.track && r_note == i_tok.note) begin
                        n_busy      = 1'b0;
                        n_off       = 1'b1;
                        n_rev       = 1'b0;
                        n_tok.found = 1'b1;
                        n_tok.voice = i_idx;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_tok.valid) begin
            if (n_on)  n_tok.on_mask  = i_tok.on_mask | i_bit;
            if (n_off) n_tok.off_mask = i_tok.off_mask | i_bit;
            if (n_rev) n_tok.rev_mask = i_tok.rev_mask | i_bit;
            // tick reports the key bits first, then clears them
            if (i_tok.action == ACT_TICK) begin
                n_on  = 1'b0;
                n_off = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_on        <= 1'b0;
            r_off       <= 1'b0;
            r_rev       <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_on   <= n_on;
            r_off  <= n_off;
            r_rev  <= n_rev;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_claim) begin
            r_track <= i_tok.track;
            r_note  <= i_tok.note;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/voice_allocator_key_masks.sv =====
// Voice allocator: each transaction is a note-on, note-off or tick (in tuser) and returns
// exactly one result. The voices form a chain of cells, one per voice; a request steps
// through one cell per clock. A new one is accepted only once the previous request has
// left the chain and the spare result slot is empty, so only one transaction is in the
// chain at a time. A note-on claims the lowest free voice, a note-off frees the lowest
// busy voice owned by the same track
// and note, and a tick reports then clears the key-on and key-off masks. The reverb mask
// persists. Found is 0 (and voice 0) when nothing was allocated or freed. A finished
// result waits in an output register backed by one spare slot.
module voice_allocator_key_masks (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // track[7:0], note[14:8], reverb_on[15]
    input  logic [vak_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [vak_pkg::ACT_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // voice[4:0], key_on_mask[28:5], key_off_mask[52:29], reverb_mask[76:53], zeros[79:77]
    output logic [vak_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // found[0]
    output logic                             m_axis_tuser
);
    import vak_pkg::*;

    localparam int RES_W = VOICE_W + 3 * MASK_W;

    t_token             w_tok [NUM_VOICES+1];
    t_token             w_exit;
    logic               w_accept;
    logic               w_drain;

    logic               r_run;
    logic               r_out_v;
    logic [RES_W-1:0]   r_out;
    logic               r_out_found;
    logic               r_hold_v;
    logic [RES_W-1:0]   r_hold;
    logic               r_hold_found;
    logic [RES_W-1:0]   w_res;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_drain  = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_run && !r_hold_v;

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].valid    = w_accept;
        w_tok[0].action   = s_axis_tuser;
        w_tok[0].track    = s_axis_tdata[TRACK_W-1:0];
        w_tok[0].note     = s_axis_tdata[TRACK_W+NOTE_W-1:TRACK_W];
        w_tok[0].rev      = s_axis_tdata[TRACK_W+NOTE_W];
    end

    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
        vak_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (VOICE_W'(g)),
            .i_bit   (MASK_W'(1) << g),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_exit = w_tok[NUM_VOICES];
    assign w_res  = {w_exit.rev_mask, w_exit.off_mask, w_exit.on_mask, w_exit.voice};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_run <= 1'b1;
            end else if (w_exit.valid) begin
                r_run <= 1'b0;
            end
            if (w_drain) begin
                if (r_hold_v) begin
                    r_hold_v <= 1'b0;
                end else if (!w_exit.valid) begin
                    r_out_v <= 1'b0;
                end
            end else if (w_exit.valid) begin
                if (r_out_v) begin
                    r_hold_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            if (r_hold_v) begin
                r_out       <= r_hold;
                r_out_found <= r_hold_found;
            end else if (w_exit.valid) begin
                r_out       <= w_res;
                r_out_found <= w_exit.found;
            end
        end else if (w_exit.valid) begin
            if (r_out_v) begin
                r_hold       <= w_res;
                r_hold_found <= w_exit.found;
            end else begin
                r_out       <= w_res;
                r_out_found <= w_exit.found;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), r_out};
    assign m_axis_tuser  = r_out_found;

    // a request leaves the chain only while one is in flight
    a_exit_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_run)
        else $error("request left the chain with none in flight");

    // only note-on and note-off can find a voice
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.valid && w_exit.found) |->
            (w_exit.action == ACT_NOTE_ON || w_exit.action == ACT_NOTE_OFF))
        else $error("voice found on a tick or unused action");

    // the spare slot fills only behind a waiting result
    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("spare result slot used while output register empty");

    // no request is taken while the chain is busy
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_run && !s_axis_tready))
        else $error("second request accepted while chain busy");

endmodule

// ===== test/voice_allocator_key_masks_test.sv =====
module voice_allocator_key_masks_test;
    import vak_pkg::*;

    // the fourth action code has no name in the package, the block ignores it
    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               found;
        logic [MASK_W-1:0]  on_mask;
        logic [MASK_W-1:0]  off_mask;
        logic [MASK_W-1:0]  rev_mask;
    } t_report;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [TRACK_W-1:0] trk;
        logic [NOTE_W-1:0]  nt;
        logic               rv;
        logic [5:0]         reps;
        logic               typed;
        t_report            want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // track[7:0], note[14:8], reverb_on[15]
    logic [ACT_W-1:0]      s_axis_tuser;   // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // voice, key_on, key_off, reverb masks, zeros
    logic                  m_axis_tuser;   // found[0]

    // shadow of the allocator
    logic               busy [NUM_VOICES];
    logic [TRACK_W-1:0] own_trk [NUM_VOICES];
    logic [NOTE_W-1:0]  own_note [NUM_VOICES];
    logic [MASK_W-1:0]  on_acc, off_acc, rev_acc;

    t_report   pending_reports [$];
    t_plan_row plan [$];
    t_report   got, want;

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 0;
    int hold_left = 0;
    int mismatches = 0;
    int n_items = 0, n_alloc = 0, n_full = 0, n_freed = 0, n_unmatched = 0, n_ticks = 0;
    int n_checked = 0;

    voice_allocator_key_masks dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("voice_allocator_key_masks_test: FAIL");
        $finish;
    end

    function automatic t_report apply_event(logic [ACT_W-1:0] act, logic [TRACK_W-1:0] trk,
                                            logic [NOTE_W-1:0] nt, logic rv);
        t_report            r;
        bit                 done;
        logic [VOICE_W-1:0] vx;
        r = '0;
        done = 0;
        if (act == ACT_NOTE_ON) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                vx = VOICE_W'(v);
                if (!done && !busy[vx]) begin
                    busy[vx] = 1'b1;
                    own_trk[vx] = trk;
                    own_note[vx] = nt;
                    on_acc[vx] = 1'b1;
                    rev_acc[vx] = rv;
                    r.voice = vx;
                    r.found = 1'b1;
                    done = 1;
                end
            end
        end else if (act == ACT_NOTE_OFF) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                vx = VOICE_W'(v);
                if (!done && busy[vx] && own_trk[vx] == trk && own_note[vx] == nt) begin
                    busy[vx] = 1'b0;
                    off_acc[vx] = 1'b1;
                    rev_acc[vx] = 1'b0;
                    r.voice = vx;
                    r.found = 1'b1;
                    done = 1;
                end
            end
        end
        r.on_mask = on_acc;
        r.off_mask = off_acc;
        if (act == ACT_TICK) begin
            on_acc = '0;
            off_acc = '0;
        end
        r.rev_mask = rev_acc;
        return r;
    endfunction

    task automatic send_event(input logic [ACT_W-1:0] act, input logic [TRACK_W-1:0] trk,
                              input logic [NOTE_W-1:0] nt, input logic rv,
                              input logic typed, input t_report typed_want);
        t_report r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rv, nt, trk};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        r = apply_event(act, trk, nt, rv);
        pending_reports.push_back(typed ? typed_want : r);
        n_items++;
        if (act == ACT_NOTE_ON) begin
            if (r.found) n_alloc++; else n_full++;
        end else if (act == ACT_NOTE_OFF) begin
            if (r.found) n_freed++; else n_unmatched++;
        end else if (act == ACT_TICK) begin
            n_ticks++;
        end
    endtask

    // sender pauses until every report is back
    task automatic drain_reports();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(logic [ACT_W-1:0] act, logic [TRACK_W-1:0] trk,
                           logic [NOTE_W-1:0] nt, logic rv, int reps, logic typed,
                           logic [VOICE_W-1:0] v, logic f, logic [MASK_W-1:0] on_m,
                           logic [MASK_W-1:0] off_m, logic [MASK_W-1:0] rev_m);
        t_plan_row row;
        row.act = act;
        row.trk = trk;
        row.nt = nt;
        row.rv = rv;
        row.reps = 6'(reps);
        row.typed = typed;
        row.want = '{voice: v, found: f, on_mask: on_m, off_mask: off_m, rev_mask: rev_m};
        plan.push_back(row);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val,
                     act_val);
        end
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.voice = m_axis_tdata[4:0];
            got.found = m_axis_tuser;
            got.on_mask = m_axis_tdata[28:5];
            got.off_mask = m_axis_tdata[52:29];
            got.rev_mask = m_axis_tdata[76:53];
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none, got voice %0d found %0b",
                         $time, got.voice, got.found);
            end else begin
                want = pending_reports.pop_front();
                n_checked++;
                check_field("voice", 32'(want.voice), 32'(got.voice));
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("key_on_mask", 32'(want.on_mask), 32'(got.on_mask));
                check_field("key_off_mask", 32'(want.off_mask), 32'(got.off_mask));
                check_field("reverb_mask", 32'(want.rev_mask), 32'(got.rev_mask));
                check_field("tdata padding", 32'd0, 32'(m_axis_tdata[79:77]));
            end
        end
    end

    initial begin
        logic [ACT_W-1:0]   act;
        logic [TRACK_W-1:0] trk;
        logic [NOTE_W-1:0]  nt;
        logic               rv;
        int                 pick;
        int                 owners [$];

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        busy = '{default: 1'b0};
        own_trk = '{default: '0};
        own_note = '{default: '0};
        on_acc = '0;
        off_acc = '0;
        rev_acc = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        //      action        track  note   rev reps typed voice found on  off rev
        add_row(ACT_TICK,     8'd0,  7'd0,  0, 1, 1, 0, 0, 24'd0, 24'd0, 24'd0);
        add_row(ACT_NOTE_OFF, 8'd255, 7'd127, 0, 1, 1, 0, 0, 24'd0, 24'd0, 24'd0);
        add_row(ACT_NOTE_ON,  8'd255, 7'd127, 1, 1, 1, 0, 1, 24'd1, 24'd0, 24'd1);
        add_row(ACT_NOTE_ON,  8'd0,  7'd0,  0, 1, 1, 1, 1, 24'd3, 24'd0, 24'd1);
        add_row(ACT_IGNORED,  8'hAA, 7'h55, 1, 1, 1, 0, 0, 24'd3, 24'd0, 24'd1);
        add_row(ACT_NOTE_OFF, 8'd255, 7'd127, 0, 1, 1, 0, 1, 24'd3, 24'd1, 24'd0);
        add_row(ACT_NOTE_OFF, 8'd255, 7'd127, 0, 1, 1, 0, 0, 24'd3, 24'd1, 24'd0);
        // second owner of track 0 note 0, then release takes the lowest one
        add_row(ACT_NOTE_ON,  8'd0,  7'd0,  1, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_OFF, 8'd0,  7'd0,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,     8'hFF, 7'h7F, 1, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,     8'd0,  7'd0,  0, 1, 0, 0, 0, 0, 0, 0);
        // fill every voice, the last note-on of the run and the one after it find none free
        add_row(ACT_NOTE_ON,  8'd7,  7'd1,  1, 24, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_ON,  8'd9,  7'd9,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_OFF, 8'd7,  7'd5,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_OFF, 8'd0,  7'd0,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_ON,  8'd3,  7'd3,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,     8'd0,  7'd0,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_OFF, 8'd7,  7'd1,  0, 24, 0, 0, 0, 0, 0, 0);
        add_row(ACT_NOTE_OFF, 8'd3,  7'd3,  0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,     8'd0,  7'd0,  0, 1, 0, 0, 0, 0, 0, 0);

        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                send_event(plan[i].act, plan[i].trk, NOTE_W'(plan[i].nt + k), plan[i].rv,
                           plan[i].typed, plan[i].want);
            end
        end
        drain_reports();

        // phases: no idling, sender idle, receiver stalling, both, then no idling again
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                3: begin idle_pct = 38; stall_pct = 38; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 100; n++) begin
                if (phase == 0 && n == 40) hold_req = 1;
                trk = TRACK_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 255));
                nt = NOTE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 127));
                rv = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    act = ACT_NOTE_ON;
                end else if (pick < 80) begin
                    act = ACT_NOTE_OFF;
                    owners.delete();
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (busy[VOICE_W'(v)]) owners.push_back(v);
                    end
                    if (owners.size() != 0) begin
                        pick = owners[$urandom_range(0, owners.size() - 1)];
                        trk = own_trk[VOICE_W'(pick)];
                        nt = own_note[VOICE_W'(pick)];
                    end
                end else if (pick < 88) begin
                    act = ACT_NOTE_OFF;
                end else if (pick < 97) begin
                    act = ACT_TICK;
                end else begin
                    act = ACT_IGNORED;
                end
                send_event(act, trk, nt, rv, 1'b0, '0);
            end
            drain_reports();
        end

        repeat (40) @(posedge i_clk);
        $display("ran %0d events: %0d allocations, %0d refused with all voices busy,",
                 n_items, n_alloc, n_full);
        $display("%0d releases, %0d unmatched releases, %0d ticks; %0d results checked",
                 n_freed, n_unmatched, n_ticks, n_checked);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("voice_allocator_key_masks_test: PASS");
        end else begin
            $display("voice_allocator_key_masks_test: FAIL");
        end
        $finish;
    end

endmodule
